/* sv/i2cmux_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmux_pkg
// shared types, codes and defaults for the i2c mux slot tracker
// ----------------------------------------------------------------------------
package i2cmux_pkg;

  // default sizing
  localparam int NUM_EXTENDERS_DEF      = 8;
  localparam int SLOTS_PER_EXTENDER_DEF = 8;

  // item modes
  localparam logic [1:0] MODE_PRESENCE = 2'd0;
  localparam logic [1:0] MODE_NEXT     = 2'd1;
  localparam logic [1:0] MODE_MASK_REQ = 2'd2;
  localparam logic [1:0] MODE_DONE     = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_WRITE   = 2'd1;
  localparam logic [1:0] ST_BAD_IDX = 2'd2;
  localparam logic [1:0] ST_ACK_ERR = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ADDRESS = 2'd2;

  // configuration reset values
  localparam logic       ENABLED_RST     = 1'b1;
  localparam logic [6:0] MIN_ADDRESS_RST = 7'd112;
  localparam logic [6:0] MAX_ADDRESS_RST = 7'd119;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] address;
    logic       responding;
    logic [6:0] slot_number;
    logic [3:0] extender_index;
    logic [7:0] slot_mask;
    logic       force_req;
    logic       ack_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] write_address;
    logic [7:0] write_data;
    logic [6:0] next_slot;
    logic [3:0] extender_count;
    logic       layout_changed;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic exec;
  } dp_cmd_t;

endpackage

/* sv/i2cmux_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmux_ctrl
// sequencing of capture, execute and result hand-off
// ----------------------------------------------------------------------------
module i2cmux_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cmux_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // result register empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt   = state_r;
    cmd.load_in = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.exec ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // a captured beat always moves to the execute state
  a_load_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_EXEC))
    else $error("captured beat did not move to execute");

  // execution never overwrites an untaken result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  // execution always presents a result
  a_exec_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("executed beat produced no result");

  // execute waits while the result is held
  a_exec_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && out_valid_r && out_stall) |=> (state_r == S_EXEC))
    else $error("left execute with a blocked result");

endmodule

/* sv/i2cmux_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmux_dp
// item register, configuration, extender tables and result register
// ----------------------------------------------------------------------------
module i2cmux_dp #(
  parameter int NUM_EXTENDERS      = i2cmux_pkg::NUM_EXTENDERS_DEF,
  parameter int SLOTS_PER_EXTENDER = i2cmux_pkg::SLOTS_PER_EXTENDER_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  i2cmux_pkg::dp_cmd_t                 cmd,
  input  i2cmux_pkg::in_item_t                in_data,
  output i2cmux_pkg::out_item_t               out_data,
  input  logic                                cfg_we,
  input  logic [i2cmux_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [i2cmux_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int IDX_W = (NUM_EXTENDERS > 1) ? $clog2(NUM_EXTENDERS) : 1;
  localparam logic [6:0] NUM_W7 = 7'(NUM_EXTENDERS);
  localparam logic [4:0] NUM_W5 = 5'(NUM_EXTENDERS);

  i2cmux_pkg::in_item_t  item_r;
  i2cmux_pkg::out_item_t res_r, res_nxt;

  logic       enabled_r;
  logic [6:0] min_addr_r;
  logic [6:0] max_addr_r;

  logic [NUM_EXTENDERS-1:0] det_r, det_nxt;
  logic [NUM_EXTENDERS-1:0] onl_r, onl_nxt;
  logic [NUM_EXTENDERS-1:0] mv_r, mv_nxt;
  logic [7:0]               masks_r   [NUM_EXTENDERS];
  logic [7:0]               masks_nxt [NUM_EXTENDERS];
  logic [3:0]               cnt_r, cnt_nxt;

  logic [6:0]       off;
  logic             in_window;
  logic [IDX_W-1:0] ev_ix;
  logic [IDX_W-1:0] rq_ix;
  logic             idx_bad;
  logic             force_wr;
  logic [7:0]       cur;
  logic [7:0]       next_val;

  assign off       = item_r.address - min_addr_r;
  assign in_window = enabled_r && (item_r.address >= min_addr_r) &&
                     (item_r.address <= max_addr_r) && (off < NUM_W7);
  assign ev_ix     = off[IDX_W-1:0];
  assign rq_ix     = item_r.extender_index[IDX_W-1:0];
  assign idx_bad   = ({1'b0, item_r.extender_index} >= NUM_W5);
  assign cur       = {1'b0, item_r.slot_number};

  // slot search over detected extenders, lowest one wins
  always_comb begin
    logic [7:0] first;
    logic [7:0] last;
    next_val = '0;
    for (int i = NUM_EXTENDERS - 1; i >= 0; i--) begin
      first = 8'(i * SLOTS_PER_EXTENDER);
      last  = first + 8'(SLOTS_PER_EXTENDER - 1);
      if (det_r[i] && (cur <= last)) begin
        next_val = ((cur > first) ? cur : first) + 8'd1;
      end
    end
  end

  always_comb begin
    det_nxt   = det_r;
    onl_nxt   = onl_r;
    mv_nxt    = mv_r;
    masks_nxt = masks_r;
    cnt_nxt   = cnt_r;
    res_nxt   = '0;
    force_wr  = 1'b0;
    if (cmd.exec) begin
      unique case (item_r.mode)
        i2cmux_pkg::MODE_PRESENCE: begin
          if (in_window) begin
            if (item_r.responding) begin
              if (!det_r[ev_ix]) begin
                if (cnt_r != 4'hF) begin
                  cnt_nxt = cnt_r + 4'd1;
                end
                res_nxt.layout_changed = 1'b1;
                mv_nxt[ev_ix]          = 1'b0;
              end
              det_nxt[ev_ix] = 1'b1;
            end else if (det_r[ev_ix]) begin
              res_nxt.layout_changed = 1'b1;
            end
            onl_nxt[ev_ix] = item_r.responding;
          end
        end
        i2cmux_pkg::MODE_NEXT: begin
          res_nxt.next_slot = next_val[6:0];
        end
        i2cmux_pkg::MODE_MASK_REQ: begin
          if (idx_bad) begin
            res_nxt.status = i2cmux_pkg::ST_BAD_IDX;
          end else begin
            // unwritten mask forces a write
            force_wr      = item_r.force_req || !mv_r[rq_ix];
            mv_nxt[rq_ix] = 1'b1;
            if (force_wr || (masks_r[rq_ix] != item_r.slot_mask)) begin
              res_nxt.status        = i2cmux_pkg::ST_WRITE;
              res_nxt.write_address = min_addr_r + {3'b000, item_r.extender_index};
              res_nxt.write_data    = item_r.slot_mask;
            end
          end
        end
        i2cmux_pkg::MODE_DONE: begin
          if (idx_bad) begin
            res_nxt.status = i2cmux_pkg::ST_BAD_IDX;
          end else if (item_r.ack_ok) begin
            masks_nxt[rq_ix] = item_r.slot_mask;
          end else begin
            mv_nxt[rq_ix]  = 1'b0;
            res_nxt.status = i2cmux_pkg::ST_ACK_ERR;
          end
        end
        default: res_nxt = '0;
      endcase
    end
    res_nxt.extender_count = cnt_nxt;
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item_r <= in_data;
    end
    if (cmd.exec) begin
      res_r <= res_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= i2cmux_pkg::ENABLED_RST;
      min_addr_r <= i2cmux_pkg::MIN_ADDRESS_RST;
      max_addr_r <= i2cmux_pkg::MAX_ADDRESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2cmux_pkg::CFG_ENABLED:     enabled_r  <= cfg_wdata[0];
        i2cmux_pkg::CFG_MIN_ADDRESS: min_addr_r <= cfg_wdata;
        i2cmux_pkg::CFG_MAX_ADDRESS: max_addr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // extender tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_r <= '0;
      onl_r <= '0;
      mv_r  <= '0;
      cnt_r <= '0;
      for (int i = 0; i < NUM_EXTENDERS; i++) begin
        masks_r[i] <= '0;
      end
    end else begin
      det_r   <= det_nxt;
      onl_r   <= onl_nxt;
      mv_r    <= mv_nxt;
      cnt_r   <= cnt_nxt;
      masks_r <= masks_nxt;
    end
  end

  assign out_data = res_r;

  // detection is sticky
  a_det_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (det_r & ~det_nxt) == '0)
    else $error("detected flag cleared");

  // count only moves on a new detection
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_nxt != cnt_r) |-> ((det_nxt != det_r) && (cnt_nxt == cnt_r + 4'd1)))
    else $error("count changed without a new detection");

  // tables only change when executing
  a_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.exec |=> ($stable(det_r) && $stable(mv_r) && $stable(cnt_r)))
    else $error("tables changed outside execute");

endmodule

/* sv/i2c_mux_slot_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_mux_slot_tracker
// tracks i2c mux extenders in an address window and their channel masks
// ----------------------------------------------------------------------------
// Each input beat is one of four items: a presence event for an address in
// the min..max window (marks an extender detected, counts it, invalidates
// its cached mask and records online state; an offline event for a detected
// extender reports a layout change but never clears detection), a next-slot
// query (returns the following 1-based slot on a detected extender, 0 for
// the main bus), a mask request (says whether a channel mask must be written
// and where) and a write completion (stores the mask on ack, otherwise marks
// it unwritten). Every beat gives exactly one result beat. Each item is first
// captured into the item register; then the datapath updates the flag tables
// and loads the result register. A new beat is not taken until the captured
// item has executed. The input side can still take one beat while a finished
// result waits for the sink; execution of that captured item then holds
// until the result register is taken. Configuration registers (enable, min
// address, max address) take effect from the next item; the user must write
// them only while the block is idle, and the block does not enforce it.
// ----------------------------------------------------------------------------
module i2c_mux_slot_tracker #(
  parameter int NUM_EXTENDERS      = i2cmux_pkg::NUM_EXTENDERS_DEF,
  parameter int SLOTS_PER_EXTENDER = i2cmux_pkg::SLOTS_PER_EXTENDER_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input beats
  input  logic                              in_valid,
  output logic                              in_stall,
  input  i2cmux_pkg::in_item_t              in_data,
  // result beats
  output logic                              out_valid,
  input  logic                              out_stall,
  output i2cmux_pkg::out_item_t             out_data,
  // register writes
  input  logic                              cfg_we,
  input  logic [i2cmux_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cmux_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // capture / execute commands from the controller
  i2cmux_pkg::dp_cmd_t cmd;

  // sequencing: capture, execute, result hand-off
  i2cmux_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // tables, configuration and result register
  i2cmux_dp #(
    .NUM_EXTENDERS      (NUM_EXTENDERS),
    .SLOTS_PER_EXTENDER (SLOTS_PER_EXTENDER)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

/* sim/slot_tracker_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_tracker_monitor
// watches the i2c mux slot tracker ports, predicts every answer and checks it
// ----------------------------------------------------------------------------
// Keeps its own copy of the extender flag tables and of the register
// settings, computes the answer for each accepted input beat and compares
// each accepted result beat field by field against the oldest waiting one.
// ----------------------------------------------------------------------------
module slot_tracker_monitor
  import i2cmux_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                   mismatches,
  output int                   outstanding,
  output int                   checked
);

  localparam int NUM_EXT = NUM_EXTENDERS_DEF;
  localparam int SLOTS   = SLOTS_PER_EXTENDER_DEF;

  logic       cfg_enabled;
  logic [6:0] cfg_min;
  logic [6:0] cfg_max;

  bit         seen       [NUM_EXT];
  bit         online     [NUM_EXT];
  bit         mask_known [NUM_EXT];
  logic [7:0] mask_cache [NUM_EXT];
  logic [3:0] seen_total;

  out_item_t  pending_answers[$];

  // answer for one item, updating the extender tables on the way
  function automatic out_item_t answer_for(input in_item_t it);
    out_item_t r;
    int        offset;
    int        slot;
    int        first;
    bit        found;
    bit        forced;
    r = '0;
    case (it.mode)
      MODE_PRESENCE: begin
        offset = int'(it.address) - int'(cfg_min);
        if (cfg_enabled && it.address >= cfg_min && it.address <= cfg_max &&
            offset < NUM_EXT) begin
          if (it.responding) begin
            if (!seen[offset]) begin
              if (seen_total < 4'd15) seen_total++;
              r.layout_changed = 1'b1;
              mask_known[offset] = 1'b0;
            end
            seen[offset] = 1'b1;
          end else if (seen[offset]) begin
            r.layout_changed = 1'b1;
          end
          online[offset] = it.responding;
        end
      end
      MODE_NEXT: begin
        slot  = int'(it.slot_number);
        found = 1'b0;
        for (int i = 0; i < NUM_EXT; i++) begin
          first = i * SLOTS;
          if (!found && seen[i] && slot <= first + SLOTS - 1) begin
            r.next_slot = 7'(((slot > first) ? slot : first) + 1);
            found = 1'b1;
          end
        end
      end
      default: begin
        if (it.extender_index >= NUM_EXT) begin
          r.status = ST_BAD_IDX;
        end else if (it.mode == MODE_MASK_REQ) begin
          forced = it.force_req;
          // a mask never written counts as a forced write
          if (!mask_known[it.extender_index]) begin
            forced = 1'b1;
            mask_known[it.extender_index] = 1'b1;
          end
          if (forced || mask_cache[it.extender_index] != it.slot_mask) begin
            r.status        = ST_WRITE;
            r.write_address = cfg_min + 7'(it.extender_index);
            r.write_data    = it.slot_mask;
          end
        end else if (it.ack_ok) begin
          mask_cache[it.extender_index] = it.slot_mask;
        end else begin
          mask_known[it.extender_index] = 1'b0;
          r.status = ST_ACK_ERR;
        end
      end
    endcase
    r.extender_count = seen_total;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("result %0d: %s expected %0h, got %0h", checked, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      cfg_enabled = ENABLED_RST;
      cfg_min     = MIN_ADDRESS_RST;
      cfg_max     = MAX_ADDRESS_RST;
      for (int i = 0; i < NUM_EXT; i++) begin
        seen[i]       = 1'b0;
        online[i]     = 1'b0;
        mask_known[i] = 1'b0;
        mask_cache[i] = '0;
      end
      seen_total = '0;
      pending_answers.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_answers.size() == 0) begin
          if (mismatches < 10)
            $display("result beat with no answer waiting: %p", out_data);
          mismatches++;
        end else begin
          want = pending_answers.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("write_address", want.write_address, out_data.write_address);
          check_field("write_data", want.write_data, out_data.write_data);
          check_field("next_slot", want.next_slot, out_data.next_slot);
          check_field("extender_count", want.extender_count, out_data.extender_count);
          check_field("layout_changed", want.layout_changed, out_data.layout_changed);
          checked++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLED:     cfg_enabled = cfg_wdata[0];
          CFG_MIN_ADDRESS: cfg_min     = cfg_wdata;
          CFG_MAX_ADDRESS: cfg_max     = cfg_wdata;
          default: ;
        endcase
      end
      // new answer goes to the tail of the queue
      if (in_valid && !in_stall)
        pending_answers = {pending_answers, answer_for(in_data)};
    end
    outstanding = pending_answers.size();
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the i2c mux slot tracker
// ----------------------------------------------------------------------------
// A short directed run at the reset settings walks the corner cases of
// presence events, slot queries, mask requests and completions. Then a
// series of random phases, each under its own register setting, mixes
// presence events, queries and mask request / completion pairs. Both sides
// idle at random, one phase runs without any idling, and in one phase the
// sink holds off long enough for the block to stall its input. The monitor
// beside the block predicts and checks every result beat.
// ----------------------------------------------------------------------------
module testbench;
  import i2cmux_pkg::*;

  localparam int RAND_PER_PHASE = 225;
  localparam int NUM_PHASES     = 8;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int SINK_HOLD      = 80;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int         fail_count;
  int         outstanding;
  int         results_checked;
  int         cycle_count;
  int         mode_count[4];
  int         settings_count;
  logic [6:0] cur_min;
  // calm: no idling on either side; hold_wanted: sink does its long hold once
  bit         calm;
  bit         hold_wanted;

  always #2 clk = ~clk;

  i2c_mux_slot_tracker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  slot_tracker_monitor i_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (fail_count),
    .outstanding (outstanding),
    .checked     (results_checked)
  );

  // ---------------------------------------------------------------------------
  // item building and the input beat driver
  // ---------------------------------------------------------------------------

  // every field random, then the caller overrides the ones that matter
  function automatic in_item_t random_item(input logic [1:0] mode);
    logic [31:0] rnd;
    in_item_t it;
    rnd = $urandom;
    it = rnd[$bits(in_item_t)-1:0];
    it.mode = mode;
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input in_item_t it);
    // occasional gap with valid low, never lowered and raised in one step
    if (!calm && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    mode_count[it.mode]++;
    @(negedge clk);
  endtask

  task automatic presence(input logic [6:0] addr, input logic resp);
    in_item_t it;
    it = random_item(MODE_PRESENCE);
    it.address    = addr;
    it.responding = resp;
    send_item(it);
  endtask

  task automatic query(input logic [6:0] slot);
    in_item_t it;
    it = random_item(MODE_NEXT);
    it.slot_number = slot;
    send_item(it);
  endtask

  task automatic mask_req(input logic [3:0] idx, input logic [7:0] mask,
                          input logic frc);
    in_item_t it;
    it = random_item(MODE_MASK_REQ);
    it.extender_index = idx;
    it.slot_mask      = mask;
    it.force_req      = frc;
    send_item(it);
  endtask

  task automatic write_done(input logic [3:0] idx, input logic [7:0] mask,
                            input logic ack);
    in_item_t it;
    it = random_item(MODE_DONE);
    it.extender_index = idx;
    it.slot_mask      = mask;
    it.ack_ok         = ack;
    send_item(it);
  endtask

  // ---------------------------------------------------------------------------
  // register writes, only with the block idle
  // ---------------------------------------------------------------------------

  // wait until every answer is back and the block is idle
  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_settings(input logic en, input logic [6:0] lo,
                                input logic [6:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ENABLED;
    cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, en};
    @(negedge clk);
    cfg_index <= CFG_MIN_ADDRESS;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_index <= CFG_MAX_ADDRESS;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_we  <= 1'b0;
    cur_min = lo;
    settings_count++;
  endtask

  // ---------------------------------------------------------------------------
  // random traffic: mostly mask request / completion pairs on one extender,
  // presence events near the window and slot queries, with some noise
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_mask();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h5A;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int items);
    int         sent;
    int         pick;
    logic [3:0] idx;
    logic [7:0] mask;
    logic [6:0] addr;
    logic [6:0] slot;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // mostly addresses at or just past the window start
        if ($urandom_range(0, 3) == 0)
          addr = 7'($urandom);
        else
          addr = 7'(cur_min + $urandom_range(0, 9));
        presence(addr, $urandom_range(0, 99) < 70);
        sent++;
      end else if (pick < 45) begin
        if ($urandom_range(0, 4) == 0)
          slot = 7'($urandom);
        else
          slot = 7'($urandom_range(0, 64));
        query(slot);
        sent++;
      end else if (pick < 90) begin
        if ($urandom_range(0, 9) == 0)
          idx = 4'($urandom_range(8, 15));
        else
          idx = 4'($urandom_range(0, 7));
        mask = pick_mask();
        mask_req(idx, mask, $urandom_range(0, 3) == 0);
        sent++;
        // the write normally follows with the same mask
        if ($urandom_range(0, 9) < 8) begin
          write_done(idx, mask, $urandom_range(0, 99) < 85);
          sent++;
        end
      end else begin
        write_done(4'($urandom), 8'($urandom), 1'($urandom));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sink side: random stall, plus one long hold while the source keeps going
  // ---------------------------------------------------------------------------
  initial begin : sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_wanted && !hold_done) begin
        out_stall <= 1'b1;
        hold_left = SINK_HOLD - 1;
        hold_done = 1'b1;
      end else begin
        out_stall <= !calm && $urandom_range(0, 99) < 12;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // cycle limit
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d answers still waiting",
             cycle_count, outstanding);
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    // per phase register settings; detection never clears, so the narrow
    // windows come first and the full window late
    bit         ph_en [NUM_PHASES];
    logic [6:0] ph_lo [NUM_PHASES];
    logic [6:0] ph_hi [NUM_PHASES];
    ph_en = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
    ph_lo = '{7'd112, 7'd119, 7'd60, 7'd125, 7'd127, 7'd0, 7'd0, 7'd112};
    ph_hi = '{7'd119, 7'd112, 7'd62, 7'd127, 7'd127, 7'd127, 7'd0, 7'd119};
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    calm           = 1'b0;
    hold_wanted    = 1'b0;
    cur_min        = MIN_ADDRESS_RST;
    settings_count = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at the reset settings (enabled, window 112..119)
    query(7'd0);                  // nothing detected: main bus
    query(7'd64);
    mask_req(4'd0, 8'h00, 1'b0);  // mask never written: forced write
    write_done(4'd0, 8'h00, 1'b1);
    mask_req(4'd0, 8'h00, 1'b0);  // cached mask matches: nothing to do
    mask_req(4'd0, 8'h00, 1'b1);  // forced anyway
    mask_req(4'd0, 8'hFF, 1'b0);  // differs from cache
    write_done(4'd7, 8'hFF, 1'b0);  // no ack: error, mask unwritten
    mask_req(4'd15, 8'hFF, 1'b1); // index out of range
    write_done(4'd8, 8'h01, 1'b1);
    presence(7'd112, 1'b1);       // first and last extender detected
    presence(7'd119, 1'b1);
    presence(7'd111, 1'b1);       // just outside the window on both sides
    presence(7'd120, 1'b1);
    presence(7'd0, 1'b1);
    presence(7'd127, 1'b1);
    presence(7'd119, 1'b0);       // detected extender goes offline
    presence(7'd115, 1'b0);       // offline and never detected
    presence(7'd112, 1'b1);       // already detected: no change
    mask_req(4'd0, 8'h00, 1'b0);  // detection dropped the cached mask
    query(7'd0);
    query(7'd7);
    query(7'd8);                  // skips to the last extender
    query(7'd63);
    query(7'd127);                // beyond every slot

    // random phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      apply_settings(ph_en[p], ph_lo[p], ph_hi[p]);
      calm = (p == 5);
      if (p == 2)
        hold_wanted = 1'b1;
      random_phase(RAND_PER_PHASE);
    end

    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("ran %0d presence events, %0d slot queries, %0d mask requests, %0d completions",
             mode_count[MODE_PRESENCE], mode_count[MODE_NEXT],
             mode_count[MODE_MASK_REQ], mode_count[MODE_DONE]);
    $display("under %0d register settings, %0d result beats checked",
             settings_count, results_checked);
    if (fail_count == 0 && outstanding == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* sim.f */
sv/i2cmux_pkg.sv
sv/i2cmux_ctrl.sv
sv/i2cmux_dp.sv
sv/i2c_mux_slot_tracker.sv
sim/slot_tracker_monitor.sv
sim/testbench.sv
